[design/fbd_pkg.sv]
// Shared types and codes for the page framebuffer draw and flush block.
// Used by the core, the clip module and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

	// Command codes carried on the input tuser
	localparam logic [2:0] MODE_CLEAR   = 3'd0;
	localparam logic [2:0] MODE_FILL    = 3'd1;
	localparam logic [2:0] MODE_OUTLINE = 3'd2;
	localparam logic [2:0] MODE_PROGRESS = 3'd3;
	localparam logic [2:0] MODE_FLUSH   = 3'd4;

	// Result kinds carried on the output tuser
	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	// Widths sized for the largest screen the block supports
	localparam int COORD_W = 14;
	localparam int COL_W   = 9;
	localparam int ROW_W   = 8;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Rectangle before clipping
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
		logic   on;
		logic   kill;
	} rect_t;

	// Rectangle after clipping: [x0, x1) by [y0, y1)
	typedef struct packed {
		logic             empty;
		logic             on;
		logic [COL_W-1:0] x0;
		logic [COL_W-1:0] x1;
		logic [ROW_W-1:0] y0;
		logic [ROW_W-1:0] y1;
	} box_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_MUL,
		ST_SETUP,
		ST_RD,
		ST_WR,
		ST_ACK,
		ST_FCMD,
		ST_FRD,
		ST_FOUT
	} state_t;

endpackage

`default_nettype wire

[design/page_framebuffer_draw_flush_core.sv]
// Page framebuffer with rectangle drawing and page flush.
// A trivial item goes straight to the ack; a rectangle pass is a setup state, then a read
// and a write per store word touched; outline takes 4 passes, progress 5 after a multiply state.
// Clear: one cycle per store word (128 by default). Flush: 17 beats by default, each data word read, then sent.
// Reset: clears all 2**(page bits + word bits) store words (128 by default)
// before s_tready rises; the dirty flag resets low, column_offset resets to 2.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_draw_flush_core import fbd_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64,
	parameter int PAGE_COUNT     = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// x_pos[10:0], y_pos[21:11], rect_width[32:22], rect_height[43:33],
	// pixel_on[44], fraction[61:45], page_index[64:62], zero fill above
	input  wire logic [71:0] s_tdata,
	// mode[2:0]
	input  wire logic [2:0]  s_tuser,
	// result beat
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// command_bytes[23:0], data_word[87:24], dirty[88], zero fill above
	output logic [95:0]      m_tdata,
	// kind[1:0]
	output logic [1:0]       m_tuser,
	output logic             m_tlast,
	// column_offset register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	localparam int WORDS  = (DISPLAY_WIDTH + 7) / 8;
	localparam int WB     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PB     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int AW     = PB + WB;
	localparam int YLIM   = (DISPLAY_HEIGHT < PAGE_COUNT * 8) ? DISPLAY_HEIGHT : PAGE_COUNT * 8;
	localparam logic [WB-1:0] WORD_LAST = WB'(WORDS - 1);
	localparam logic [3:0]    PAGE_LAST = 4'(PAGE_COUNT - 1);

	state_t state_q, nxt;

	logic [2:0]         mode_q;
	logic signed [10:0] x_q, y_q, w_q, h_q;
	logic               on_q;
	logic [16:0]        frac_q;
	logic [10:0]        fill_q;
	logic [2:0]         idx_q;
	box_t               box_q;
	logic [WB-1:0]      word_q, wfirst_q, wlast_q;
	logic [PB-1:0]      page_q, plast_q;
	logic [AW-1:0]      sweep_q;
	logic               init_q;
	logic               dirty_q;
	logic [7:0]         coloff_q;
	logic               m_tvalid_q;
	logic [1:0]         kind_q;
	logic [23:0]        cmd_q;
	logic [63:0]        data_q;
	logic               last_q;
	logic               beat_dirty_q;

	// input fields
	logic signed [10:0] in_x, in_y, in_w, in_h;
	logic               in_on;
	logic [16:0]        in_frac;
	logic [2:0]         in_page;
	assign in_x    = s_tdata[10:0];
	assign in_y    = s_tdata[21:11];
	assign in_w    = s_tdata[32:22];
	assign in_h    = s_tdata[43:33];
	assign in_on   = s_tdata[44];
	assign in_frac = s_tdata[61:45];
	assign in_page = s_tdata[64:62];

	// progress fill width, registered in ST_MUL
	logic signed [11:0] wm2;
	logic [16:0]        fsat;
	logic [26:0]        prod;
	assign wm2  = 12'(w_q) - 12'sd2;
	assign fsat = frac_q[16] ? 17'h10000 : frac_q;
	assign prod = wm2[9:0] * fsat;

	// rectangle for the current pass
	rect_t  rect;
	coord_t cx, cy, cw, ch, one;
	logic   [2:0] last_idx;
	assign cx  = coord_t'(x_q);
	assign cy  = coord_t'(y_q);
	assign cw  = coord_t'(w_q);
	assign ch  = coord_t'(h_q);
	assign one = coord_t'(1);

	always_comb begin
		rect.x    = cx;
		rect.y    = cy;
		rect.w    = cw;
		rect.h    = one;
		rect.on   = 1'b1;
		rect.kill = (mode_q != MODE_FILL) && (idx_q != 3'd4) && ((w_q <= 0) || (h_q <= 0));
		case (idx_q)
			3'd0: begin
				if (mode_q == MODE_FILL) begin
					rect.h  = ch;
					rect.on = on_q;
				end
			end
			3'd1: rect.y = cy + ch - one;
			3'd2: begin
				rect.w = one;
				rect.h = ch;
			end
			3'd3: begin
				rect.x = cx + cw - one;
				rect.w = one;
				rect.h = ch;
			end
			3'd4: begin
				rect.x = cx + one;
				rect.y = cy + one;
				rect.w = coord_t'(fill_q);
				rect.h = ch - coord_t'(2);
			end
			default: rect.kill = 1'b1;
		endcase
		case (mode_q)
			MODE_FILL:    last_idx = 3'd0;
			MODE_OUTLINE: last_idx = 3'd3;
			default:      last_idx = 3'd4;
		endcase
	end

	box_t box_c;
	fbd_clip #(
		.X_LIMIT(DISPLAY_WIDTH),
		.Y_LIMIT(YLIM)
	) u_clip (
		.rect(rect),
		.box (box_c)
	);

	logic [COL_W-1:0] x1m1;
	logic [ROW_W-1:0] y1m1;
	assign x1m1 = box_c.x1 - 1'b1;
	assign y1m1 = box_c.y1 - 1'b1;

	// store
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr, cur_addr;
	logic [63:0]   rd_data, wr_data, mod_word;
	assign cur_addr = {page_q, word_q};

	fbd_store #(.ADDR_W(AW)) u_store (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// byte-wise modify of the word just read
	logic [7:0] col_in;
	logic [7:0] row_mask;
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			col_in[b] = (10'({word_q, 3'(b)}) >= 10'(box_q.x0))
				&& (10'({word_q, 3'(b)}) < 10'(box_q.x1));
			row_mask[b] = (9'({page_q, 3'(b)}) >= 9'(box_q.y0))
				&& (9'({page_q, 3'(b)}) < 9'(box_q.y1));
		end
		for (int b = 0; b < 8; b++) begin
			mod_word[8*b +: 8] = !col_in[b] ? rd_data[8*b +: 8]
				: box_q.on ? (rd_data[8*b +: 8] | row_mask)
				: (rd_data[8*b +: 8] & ~row_mask);
		end
	end

	// sequencer: next state and strobes
	logic out_free, emit, elast, word_end, page_end, rect_end, flush_end;
	logic [1:0] ekind;
	assign out_free  = !m_tvalid_q || m_tready;
	assign word_end  = (word_q == wlast_q);
	assign page_end  = (page_q == plast_q);
	assign rect_end  = (idx_q == last_idx);
	assign flush_end = (word_q == WORD_LAST);

	always_comb begin
		nxt      = state_q;
		s_tready = 1'b0;
		emit     = 1'b0;
		ekind    = KIND_ACK;
		elast    = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = cur_addr;
		wr_en    = 1'b0;
		wr_addr  = cur_addr;
		wr_data  = mod_word;
		case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
				if (sweep_q == '1) nxt = init_q ? ST_IDLE : ST_ACK;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						MODE_CLEAR:    nxt = ST_CLR;
						MODE_FILL:     nxt = ST_SETUP;
						MODE_OUTLINE:  nxt = ST_SETUP;
						MODE_PROGRESS: nxt = ST_MUL;
						MODE_FLUSH:    nxt = (4'(in_page) <= PAGE_LAST) ? ST_FCMD : ST_ACK;
						default:       nxt = ST_ACK;
					endcase
				end
			end
			ST_MUL: nxt = ST_SETUP;
			ST_SETUP: begin
				if (!box_c.empty) nxt = ST_RD;
				else if (rect_end) nxt = ST_ACK;
			end
			ST_RD: begin
				rd_en = 1'b1;
				nxt   = ST_WR;
			end
			ST_WR: begin
				wr_en = 1'b1;
				if (!(word_end && page_end)) nxt = ST_RD;
				else nxt = rect_end ? ST_ACK : ST_SETUP;
			end
			ST_ACK: begin
				if (out_free) begin
					emit = 1'b1;
					nxt  = ST_IDLE;
				end
			end
			ST_FCMD: begin
				if (out_free) begin
					emit  = 1'b1;
					ekind = KIND_CMD;
					elast = 1'b0;
					nxt   = ST_FRD;
				end
			end
			ST_FRD: begin
				rd_en = 1'b1;
				nxt   = ST_FOUT;
			end
			ST_FOUT: begin
				ekind = KIND_DATA;
				elast = flush_end;
				if (out_free) begin
					emit = 1'b1;
					nxt  = flush_end ? ST_IDLE : ST_FRD;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= nxt;
		end
	end

	// control counters, flags and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= '0;
			init_q   <= 1'b1;
			dirty_q  <= 1'b0;
			coloff_q <= 8'd2;
			idx_q    <= '0;
		end else begin
			if (cfg_valid) begin
				coloff_q <= cfg_data;
			end
			if (state_q == ST_CLR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (state_q == ST_IDLE && s_tvalid) begin
				idx_q   <= '0;
				sweep_q <= '0;
				if (s_tuser == MODE_CLEAR) begin
					init_q  <= 1'b0;
					dirty_q <= 1'b1;
				end
				if (s_tuser == MODE_FLUSH && 4'(in_page) == PAGE_LAST) begin
					dirty_q <= 1'b0;
				end
			end
			if ((state_q == ST_SETUP && box_c.empty && !rect_end)
				|| (state_q == ST_WR && word_end && page_end && !rect_end)) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// command fields and walk positions
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			mode_q <= s_tuser;
			x_q    <= in_x;
			y_q    <= in_y;
			w_q    <= in_w;
			h_q    <= in_h;
			on_q   <= in_on;
			frac_q <= in_frac;
			page_q <= PB'(in_page);
			word_q <= '0;
		end
		if (state_q == ST_MUL) begin
			fill_q <= (wm2 > 0) ? prod[26:16] : '0;
		end
		if (state_q == ST_SETUP) begin
			box_q    <= box_c;
			word_q   <= box_c.x0[WB+2:3];
			wfirst_q <= box_c.x0[WB+2:3];
			wlast_q  <= x1m1[WB+2:3];
			page_q   <= box_c.y0[PB+2:3];
			plast_q  <= y1m1[PB+2:3];
		end
		if (state_q == ST_WR) begin
			if (word_end) begin
				word_q <= wfirst_q;
				if (!page_end) page_q <= page_q + 1'b1;
			end else begin
				word_q <= word_q + 1'b1;
			end
		end
		if (state_q == ST_FOUT && emit && !flush_end) begin
			word_q <= word_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// beat fields, dirty captured so a waiting beat holds
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q       <= ekind;
			last_q       <= elast;
			beat_dirty_q <= dirty_q;
			cmd_q        <= (ekind == KIND_CMD)
				? {8'hB0 | 8'(page_q), 4'h0, coloff_q[3:0], 4'h1, coloff_q[7:4]}
				: '0;
			data_q <= (ekind == KIND_DATA) ? rd_data : '0;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = kind_q;
	assign m_tlast   = last_q;
	assign m_tdata   = {7'd0, beat_dirty_q, data_q, cmd_q};

endmodule

`default_nettype wire

[design/fbd_store.sv]
// Framebuffer memory: one 64-bit word holds eight columns of one page.
// One write port and one read port, read data registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbd_store #(
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic [63:0]            rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [63:0]       wr_data
);

	logic [63:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[design/fbd_clip.sv]
// Clips one rectangle to the visible screen and flags empty results.
// Depends on fbd_pkg for the rectangle and box types.
`timescale 1ns / 1ps
`default_nettype none

module fbd_clip import fbd_pkg::*; #(
	parameter int X_LIMIT = 128,
	parameter int Y_LIMIT = 64
) (
	input  wire rect_t rect,
	output box_t       box
);

	localparam coord_t XL = coord_t'(X_LIMIT);
	localparam coord_t YL = coord_t'(Y_LIMIT);

	coord_t xe, ye, x0s, x1s, y0s, y1s;

	always_comb begin
		xe  = rect.x + rect.w;
		ye  = rect.y + rect.h;
		x0s = (rect.x < 0) ? coord_t'(0) : rect.x;
		y0s = (rect.y < 0) ? coord_t'(0) : rect.y;
		x1s = (xe > XL) ? XL : xe;
		y1s = (ye > YL) ? YL : ye;
		box.empty = rect.kill || (rect.w <= 0) || (rect.h <= 0)
			|| (x0s >= x1s) || (y0s >= y1s);
		box.on = rect.on;
		box.x0 = x0s[COL_W-1:0];
		box.x1 = x1s[COL_W-1:0];
		box.y0 = y0s[ROW_W-1:0];
		box.y1 = y1s[ROW_W-1:0];
	end

endmodule

`default_nettype wire

[design/fbd_checker.sv]
// Port-level checker for the page framebuffer core, bound to the top level.
// Depends on fbd_pkg for the result kind codes.
`timescale 1ns / 1ps
`default_nettype none

module fbd_checker import fbd_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// an acknowledgement is always the only beat of its item
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ACK |-> m_tlast)
		else $error("ack beat without tlast");

	// the address command beat is never marked last
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_CMD |-> !m_tlast)
		else $error("command beat marked last");

	// a flush begins with its command beat, followed by a data beat
	a_cmd_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == KIND_CMD
		|=> !m_tvalid || m_tuser == KIND_DATA)
		else $error("command beat not followed by data");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

endmodule

bind page_framebuffer_draw_flush_core fbd_checker u_fbd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire
